// File: rtl/int_to_radix_ascii_unit_defines.svh
// Assertion shorthands shared by the RTL of the radix conversion unit.
// Both sample on the rising edge of clk_i and are off while rst_ni is low.
`ifndef INT_TO_RADIX_ASCII_UNIT_DEFINES_SVH
`define INT_TO_RADIX_ASCII_UNIT_DEFINES_SVH

// Same-cycle implication.
`define ITRA_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ITRA_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/itra_pkg.sv
package itra_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int RADIX_W     = 6;
  localparam int DIGIT_W     = 6;
  localparam int CHAR_W      = 7;
  localparam int CNT_W       = $clog2(2 * VALUE_WIDTH - 1);
  localparam int IDX_W       = $clog2(VALUE_WIDTH);

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);

  localparam logic [CHAR_W-1:0] MINUS_CODE = CHAR_W'(45);
  localparam logic [CHAR_W-1:0] ZERO_CODE  = CHAR_W'(48);
  // 'A' minus ten, so that digit ten maps onto 'A'.
  localparam logic [CHAR_W-1:0] ALPHA_BASE = CHAR_W'(55);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_EMIT
  } itra_state_e;

  typedef struct packed {
    logic clear;
    logic shift;
  } itra_cell_ctrl_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = CHAR_W'(d);
    if (d < DIGIT_W'(10)) begin
      return dx + ZERO_CODE;
    end
    return dx + ALPHA_BASE;
  endfunction

endpackage

// File: rtl/itra_digit_cell.sv
module itra_digit_cell
  import itra_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  itra_cell_ctrl_t      ctrl_i,
  input  logic                 step_i,
  input  logic                 carry_i,
  input  logic [RADIX_W-1:0]   radix_i,
  input  logic [DIGIT_W-1:0]   shift_digit_i,
  output logic [DIGIT_W-1:0]   digit_o,
  output logic                 carry_o
);

  logic [DIGIT_W-1:0] digit_q, digit_d;
  logic               carry_q, carry_d;
  logic [DIGIT_W:0]   dbl;
  logic [DIGIT_W:0]   sub;
  logic               ge;

  // One doubling step of the digit with the incoming bit, reduced modulo the radix.
  always_comb begin
    dbl = {digit_q, carry_i};
    sub = dbl - {1'b0, radix_i};
    ge  = (dbl >= {1'b0, radix_i});
    digit_d = digit_q;
    carry_d = carry_q;
    if (ctrl_i.clear) begin
      digit_d = '0;
      carry_d = 1'b0;
    end else if (step_i) begin
      digit_d = ge ? sub[DIGIT_W-1:0] : dbl[DIGIT_W-1:0];
      carry_d = ge;
    end else if (ctrl_i.shift) begin
      digit_d = shift_digit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= 1'b0;
    end else begin
      carry_q <= carry_d;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

  assign digit_o = digit_q;
  assign carry_o = carry_q;

endmodule

// File: rtl/int_to_radix_ascii_unit.sv
// Converts one signed VALUE_WIDTH-bit integer (32 bits) to its text form in a
// radix from 2 to 36 and streams it out as 7-bit ASCII characters, most
// significant first: a '-' for a negative value, then digits '0'-'9' and
// 'A'-'Z', with last_o marking the final character. Zero gives "0", and the
// most negative integer converts like any other. A radix below 2 is used as 2
// and one above 36 as 36. The block handles one request at a time: in_ready_o
// is high only while it is idle. After a request is taken, the magnitude is
// shifted one bit per cycle, most significant bit first, into a row of
// VALUE_WIDTH digit cells, each of which doubles its digit, adds the bit from
// its lower neighbor and reduces modulo the radix. Carries move one cell per
// cycle, so the row works skewed. For a negative value a '-' is offered
// first; the digits are then read out by shifting the row toward its top
// cell, one cell per cycle unless the consumer stalls, leading zeros
// skipped without output.
`include "int_to_radix_ascii_unit_defines.svh"

module int_to_radix_ascii_unit
  import itra_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  input  logic [RADIX_W-1:0]            radix_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [CHAR_W-1:0]             char_code_o,
  output logic                          last_o
);

  itra_state_e state_q, state_d;

  logic [CNT_W-1:0]       t_q;
  logic [IDX_W-1:0]       cnt_q;
  logic                   started_q;
  logic                   neg_q;
  logic [VALUE_WIDTH-1:0] mag_q;
  logic [RADIX_W-1:0]     radix_q;
  // Delayed step enables; cell i steps in the cycle after cell i-1.
  logic [VALUE_WIDTH-1:1] en_q;

  logic                   accept;
  logic                   show;
  logic                   advance;
  logic [VALUE_WIDTH-1:0] step_c;
  logic [VALUE_WIDTH-1:0] mag_in;
  logic [RADIX_W-1:0]     radix_in;
  itra_cell_ctrl_t        cell_ctrl;

  logic [DIGIT_W-1:0]     digit_c [VALUE_WIDTH];
  logic [VALUE_WIDTH-1:0] carry_c;

  assign accept = in_valid_i && in_ready_o;

  // Magnitude as an unsigned number; the most negative value wraps onto
  // 2^(VALUE_WIDTH-1), which is exactly its magnitude.
  assign mag_in = value_i[VALUE_WIDTH-1] ? (~$unsigned(value_i)) + VALUE_WIDTH'(1)
                                         : $unsigned(value_i);

  always_comb begin
    if (radix_i < RADIX_MIN) begin
      radix_in = RADIX_MIN;
    end else if (radix_i > RADIX_MAX) begin
      radix_in = RADIX_MAX;
    end else begin
      radix_in = radix_i;
    end
  end

  // A digit is shown once a nonzero digit has been seen, and the lowest
  // digit is always shown so that zero still prints as "0".
  assign show = started_q || (digit_c[VALUE_WIDTH-1] != '0) || (cnt_q == '0);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        if (t_q == CNT_W'(2 * VALUE_WIDTH - 2)) begin
          state_d = neg_q ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (out_ready_i) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if ((cnt_q == '0) && out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  // Output and control decode.
  always_comb begin
    in_ready_o      = 1'b0;
    out_valid_o     = 1'b0;
    char_code_o     = digit_char(digit_c[VALUE_WIDTH-1]);
    last_o          = 1'b0;
    advance         = 1'b0;
    cell_ctrl.clear = accept;
    cell_ctrl.shift = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_CONV: begin
        // The digit row runs on its own step enables; nothing is offered.
      end
      ST_SIGN: begin
        out_valid_o = 1'b1;
        char_code_o = MINUS_CODE;
      end
      ST_EMIT: begin
        out_valid_o     = show;
        last_o          = (cnt_q == '0);
        advance         = !show || out_ready_i;
        cell_ctrl.shift = advance;
      end
    endcase
  end

  // Cell 0 steps while the conversion counter is below VALUE_WIDTH, and
  // every higher cell steps in the cycle after its lower neighbor.
  assign step_c = {en_q, (state_q == ST_CONV) && (t_q < CNT_W'(VALUE_WIDTH))};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      t_q       <= '0;
      cnt_q     <= '0;
      started_q <= 1'b0;
      neg_q     <= 1'b0;
      en_q      <= '0;
    end else begin
      state_q <= state_d;
      en_q    <= step_c[VALUE_WIDTH-2:0];
      if (accept) begin
        t_q       <= '0;
        cnt_q     <= IDX_W'(VALUE_WIDTH - 1);
        started_q <= 1'b0;
        neg_q     <= value_i[VALUE_WIDTH-1];
      end else if (state_q == ST_CONV) begin
        t_q <= t_q + CNT_W'(1);
      end else if (advance) begin
        cnt_q     <= cnt_q - IDX_W'(1);
        started_q <= started_q || show;
      end
    end
  end

  // Magnitude shift register feeds the digit row one bit per cycle.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mag_q   <= mag_in;
      radix_q <= radix_in;
    end else if (step_c[0]) begin
      mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
    end
  end

  for (genvar i = 0; i < VALUE_WIDTH; i++) begin : g_cell
    logic               cin;
    logic [DIGIT_W-1:0] sin;
    if (i == 0) begin : g_low
      assign cin = mag_q[VALUE_WIDTH-1];
      assign sin = '0;
    end else begin : g_up
      assign cin = carry_c[i-1];
      assign sin = digit_c[i-1];
    end
    itra_digit_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (cell_ctrl),
      .step_i        (step_c[i]),
      .carry_i       (cin),
      .radix_i       (radix_q),
      .shift_digit_i (sin),
      .digit_o       (digit_c[i]),
      .carry_o       (carry_c[i])
    );
  end

  // The magnitude always fits in VALUE_WIDTH digits, so the top cell never carries.
  `ITRA_ASSERT_IMP(a_top_no_carry, 1'b1, !carry_c[VALUE_WIDTH-1],
                   "top digit cell carried out")
  // No character may be offered while the block waits for a new request.
  `ITRA_ASSERT_IMP(a_idle_quiet, in_ready_o, !out_valid_o, "output valid while idle")
  // A leading zero is never shown, except for the lowest digit.
  `ITRA_ASSERT_IMP(a_no_lead_zero,
                   (state_q == ST_EMIT) && out_valid_o && !started_q && (cnt_q != '0),
                   char_code_o != ZERO_CODE, "leading zero emitted")
  // The sign is only ever produced for a negative value.
  `ITRA_ASSERT_IMP(a_sign_neg, state_q == ST_SIGN, neg_q,
                   "sign emitted for a non-negative value")
  // Once the final character is taken, the block is ready for the next request.
  `ITRA_ASSERT_NXT(a_last_idle, out_valid_o && out_ready_i && last_o, in_ready_o,
                   "not idle after last character")

endmodule

// File: dv/int_to_radix_ascii_unit_tb.sv
// Testbench for the signed integer to radix text unit.
module int_to_radix_ascii_unit_tb;
  import itra_pkg::VALUE_WIDTH;
  import itra_pkg::RADIX_W;
  import itra_pkg::CHAR_W;

  // The digit alphabet, first character in the top byte.
  localparam logic [36*8-1:0] DIGIT_SET = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";
  localparam logic [7:0] MINUS_CHAR = "-";

  localparam logic signed [VALUE_WIDTH-1:0] INT_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] INT_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  localparam int RANDOM_REQUESTS = 135;
  // Long enough to cover the tail of a request in the block.
  localparam int DRAIN_CYCLES = 150;
  localparam int HOLD_OFF_CYCLES = 400;

  typedef struct {
    logic signed [VALUE_WIDTH-1:0] value;
    logic [RADIX_W-1:0]            radix;
    int unsigned                   gap;
  } conv_request_t;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic signed [VALUE_WIDTH-1:0] value_i = '0;
  logic [RADIX_W-1:0]            radix_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic [CHAR_W-1:0]             char_code_o;
  logic                          last_o;

  conv_request_t pending_requests[$];
  text_char_t    expected_text[$];

  int unsigned total_requests = 0;
  int unsigned accepted_cnt = 0;
  int unsigned chars_seen = 0;
  int unsigned numbers_seen = 0;
  int unsigned negative_cnt = 0;
  int unsigned clamped_radix_cnt = 0;
  int unsigned error_cnt = 0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;

  // Set by the hold-off process: the receiver refuses every character while it is high.
  logic hold_rx = 1'b0;
  // Set while the run is in a stretch where neither side idles.
  logic no_idle = 1'b1;

  int_to_radix_ascii_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .value_i    (value_i),
    .radix_i    (radix_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .char_code_o(char_code_o),
    .last_o     (last_o)
  );

  always #10 clk_i = ~clk_i;

  // Idle lengths: mostly none or a few cycles, now and then a long one.
  function automatic int unsigned pick_idle();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end else if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Works out the characters that one request must produce and appends them
  // to the expected text. The radix is clamped to 2..36, and the magnitude is
  // held one bit wider than the value so the most negative integer is exact.
  function automatic void predict_text(input logic signed [VALUE_WIDTH-1:0] val,
                                       input logic [RADIX_W-1:0] rdx);
    logic [VALUE_WIDTH:0] mag;
    logic [VALUE_WIDTH:0] base;
    logic [5:0]           digits[VALUE_WIDTH+1];
    int                   n_digits;
    logic                 neg;
    text_char_t           tc;
    logic [7:0]           ascii;
    n_digits = 0;
    neg = val[VALUE_WIDTH-1];
    if (rdx < RADIX_W'(2)) begin
      base = (VALUE_WIDTH+1)'(2);
    end else if (rdx > RADIX_W'(36)) begin
      base = (VALUE_WIDTH+1)'(36);
    end else begin
      base = (VALUE_WIDTH+1)'(rdx);
    end
    if (neg) begin
      mag = {1'b1, {VALUE_WIDTH{1'b0}}} - {1'b0, val};
    end else begin
      mag = {1'b0, val};
    end
    // Digits come out least significant first; zero still yields one digit.
    do begin
      digits[n_digits] = 6'(mag % base);
      mag = mag / base;
      n_digits++;
    end while (mag != 0);
    if (neg) begin
      tc.code = MINUS_CHAR[CHAR_W-1:0];
      tc.last = 1'b0;
      expected_text.push_back(tc);
    end
    for (int k = n_digits - 1; k >= 0; k--) begin
      ascii = DIGIT_SET[(35 - digits[k]) * 8 +: 8];
      tc.code = ascii[CHAR_W-1:0];
      tc.last = (k == 0);
      expected_text.push_back(tc);
    end
  endfunction

  task automatic add_request(input logic signed [VALUE_WIDTH-1:0] val,
                             input logic [RADIX_W-1:0] rdx, input int unsigned gap);
    conv_request_t req;
    req.value = val;
    req.radix = rdx;
    req.gap = gap;
    pending_requests.push_back(req);
    total_requests++;
  endtask

  // Random values lean on the interesting regions: tiny magnitudes, powers of
  // two and the extremes, besides plain uniform draws over the whole range.
  function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
    logic signed [VALUE_WIDTH-1:0] v;
    case ($urandom_range(0, 9))
      0, 1: begin
        v = VALUE_WIDTH'($urandom_range(0, 100));
        if ($urandom_range(0, 1)) begin
          v = -v;
        end
      end
      2: begin
        case ($urandom_range(0, 4))
          0: v = INT_MIN;
          1: v = INT_MAX;
          2: v = '0;
          3: v = '1;
          default: v = INT_MIN + 1;
        endcase
      end
      3: begin
        v = VALUE_WIDTH'(1) << $urandom_range(0, VALUE_WIDTH - 1);
        if ($urandom_range(0, 1)) begin
          v = v - 1;
        end
      end
      default: v = VALUE_WIDTH'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [RADIX_W-1:0] pick_radix();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 6) begin
      return RADIX_W'($urandom_range(0, 1));
    end else if (roll < 14) begin
      return RADIX_W'($urandom_range(37, 63));
    end else if (roll < 24) begin
      return RADIX_W'(2);
    end
    return RADIX_W'($urandom_range(2, 36));
  endfunction

  // Driver. A request stays on the port until the block takes it; the next
  // one goes out after the idle gap that the finished request carried. The
  // expected characters are worked out on the edge where a request is taken.
  always @(posedge clk_i) begin
    conv_request_t req;
    logic          taken;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
    end else begin
      taken = in_valid_i && in_ready_o;
      if (taken) begin
        predict_text(value_i, radix_i);
        accepted_cnt++;
        if (value_i[VALUE_WIDTH-1]) begin
          negative_cnt++;
        end
        if (radix_i < RADIX_W'(2) || radix_i > RADIX_W'(36)) begin
          clamped_radix_cnt++;
        end
      end
      if (!in_valid_i || taken) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          req = pending_requests.pop_front();
          in_valid_i <= 1'b1;
          value_i <= req.value;
          radix_i <= req.radix;
          send_gap = no_idle ? 0 : req.gap;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor. Every character taken is checked against the oldest expected
  // one; the ready line idles at random between characters and drops for
  // the whole of a hold-off.
  always @(posedge clk_i) begin
    text_char_t exp_char;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        chars_seen++;
        if (last_o) begin
          numbers_seen++;
        end
        if (expected_text.size() == 0) begin
          $error("unexpected character 0x%02h (last %0b) with nothing pending",
                 char_code_o, last_o);
          error_cnt++;
        end else begin
          exp_char = expected_text.pop_front();
          if (char_code_o !== exp_char.code) begin
            $error("char_code mismatch: expected 0x%02h, actual 0x%02h",
                   exp_char.code, char_code_o);
            error_cnt++;
          end
          if (last_o !== exp_char.last) begin
            $error("last mismatch: expected %0b, actual %0b", exp_char.last, last_o);
            error_cnt++;
          end
        end
        recv_gap = no_idle ? 0 : pick_idle();
      end
      if (hold_rx) begin
        out_ready_i <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Long receiver hold-off in the middle of the random part. The sender keeps
  // offering, so the block fills with a finished number and must hold off
  // its own input until the receiver comes back.
  initial begin
    while (accepted_cnt < 60) begin
      @(posedge clk_i);
    end
    hold_rx <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  // The idle-free stretches: the directed part, and a run of random requests
  // further on.
  initial begin
    while (accepted_cnt < 25) begin
      @(posedge clk_i);
    end
    no_idle <= 1'b0;
    while (accepted_cnt < 110) begin
      @(posedge clk_i);
    end
    no_idle <= 1'b1;
    while (accepted_cnt < 130) begin
      @(posedge clk_i);
    end
    no_idle <= 1'b0;
  end

  initial begin
    // Directed part: zero in radix 10 and 36, both integer extremes in
    // radix 2, 10 and 36, letters up to 'Z', a radix below and above the legal
    // range, and a few mixed bit patterns.
    add_request('0, RADIX_W'(10), 0);
    add_request('0, RADIX_W'(36), 0);
    add_request('1, RADIX_W'(10), 0);
    add_request(VALUE_WIDTH'(1), RADIX_W'(2), 0);
    add_request(INT_MAX, RADIX_W'(2), 0);
    add_request(INT_MIN, RADIX_W'(2), 0);
    add_request(INT_MIN, RADIX_W'(10), 0);
    add_request(INT_MAX, RADIX_W'(10), 0);
    add_request(INT_MIN, RADIX_W'(36), 0);
    add_request(INT_MAX, RADIX_W'(36), 0);
    add_request(VALUE_WIDTH'(35), RADIX_W'(36), 0);
    add_request(VALUE_WIDTH'(36), RADIX_W'(36), 0);
    add_request(-VALUE_WIDTH'(255), RADIX_W'(16), 0);
    add_request(VALUE_WIDTH'('hDEADBEEF), RADIX_W'(16), 0);
    add_request(VALUE_WIDTH'(1000), RADIX_W'(0), 0);
    add_request(-VALUE_WIDTH'(1000), RADIX_W'(1), 0);
    add_request(VALUE_WIDTH'(12345), RADIX_W'(37), 0);
    add_request(-VALUE_WIDTH'(12345), RADIX_W'(63), 0);
    add_request(VALUE_WIDTH'(35), RADIX_W'(63), 0);
    add_request('1, RADIX_W'(63), 0);
    add_request(VALUE_WIDTH'('h55555555), RADIX_W'(4), 0);
    add_request(VALUE_WIDTH'('hAAAAAAAA), RADIX_W'(8), 0);
    add_request(VALUE_WIDTH'(999999999), RADIX_W'(3), 0);
    add_request(INT_MAX, RADIX_W'(7), 0);
    add_request(INT_MIN + 1, RADIX_W'(35), 0);
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      add_request(pick_value(), pick_radix(), pick_idle());
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Everything handed over, then every expected character back, then a
    // quiet tail long enough for one more conversion to show up if the block
    // invented one.
    while (accepted_cnt < total_requests) begin
      @(posedge clk_i);
    end
    while (expected_text.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Converted %0d numbers (%0d negative, %0d with a radix outside 2..36)",
             accepted_cnt, negative_cnt, clamped_radix_cnt);
    $display("into %0d characters, %0d of them closing a number.", chars_seen, numbers_seen);
    if (error_cnt == 0) begin
      $display("int_to_radix_ascii_unit regression: pass");
    end else begin
      $display("int_to_radix_ascii_unit regression: fail");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest legal run.
  initial begin
    #20000000;
    $display("int_to_radix_ascii_unit regression: fail");
    $finish;
  end

endmodule
